// ----- rtl/core/rgb_led_strip_bit_serializer_unit_macros.svh -----
// Assertion macros for the LED strip serializer
`ifndef RGB_LED_STRIP_BIT_SERIALIZER_UNIT_MACROS_SVH
`define RGB_LED_STRIP_BIT_SERIALIZER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define LSBS_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define LSBS_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define LSBS_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg)
`define LSBS_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- rtl/core/lsbs_pkg.sv -----
package lsbs_pkg;

	localparam int BUF_BYTES = 256;
	localparam int ADDR_W    = $clog2(BUF_BYTES);
	localparam int FILL_W    = ADDR_W + 1;
	localparam int TICK_W    = 16;
	localparam int PER_W     = 10;
	localparam int CNT_W     = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int IN_DAT_W  = 56;
	localparam int OUT_DAT_W = 8;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_SEND = 2'd1;
	localparam logic [1:0] PH_GAP  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAP       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WHITE     = 3'd4;

	localparam int IN_RED    = 0;
	localparam int IN_GREEN  = 8;
	localparam int IN_BLUE   = 16;
	localparam int IN_WHITE  = 24;
	localparam int IN_BRIGHT = 32;
	localparam int IN_COUNT  = 40;
	localparam int IN_FOLLOW = 50;

	localparam int OUT_PIN    = 0;
	localparam int OUT_BUSY   = 1;
	localparam int OUT_STATUS = 2;

	typedef struct packed {
		logic             start;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [7:0]       white;
		logic [7:0]       brightness;
		logic [CNT_W-1:0] count;
		logic             four;
	} lsbs_load_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [FILL_W-1:0] fill;
		logic [7:0]        first_byte;
	} lsbs_buf_stat_t;

	typedef struct packed {
		logic any;
		logic tick;
		logic start_frame;
	} lsbs_step_t;

	typedef struct packed {
		logic [PER_W-1:0]  zero_high;
		logic [PER_W-1:0]  one_high;
		logic [PER_W-1:0]  period;
		logic [TICK_W-1:0] gap;
	} lsbs_cfg_t;

	typedef struct packed {
		logic pin;
		logic busy_next;
		logic can_load;
		logic idle;
		logic clear_fill;
	} lsbs_ser_stat_t;

	function automatic logic [7:0] scale_level(input logic [7:0] c, input logic [7:0] b);
		logic [15:0] prod;
		prod = ({8'd0, c} * {8'd0, b}) + 16'd255;
		return prod[15:8];
	endfunction

endpackage

// ----- rtl/core/rgb_led_strip_bit_serializer_unit.sv -----
// Channel   Direction  Payload
// s_*       in         tuser: cmd; tdata: red, green, blue, white, brightness,
//                      pixel_count, following
// m_*       out        tdata: pin_level, busy_res, status
// cfg_*     in         cfg_index selects register, cfg_data carries its value
//
// A tick, a refused load and a load of zero pixels each produce one result.
// An accepted load writes one byte a cycle into the pixel memory; no item is
// taken meanwhile, and its result follows once the fill is done.
// The result register lets a new item in while m_tready is high or the register
// is empty. Reset starts the low gap; the pixel memory needs no clearing pass.
`include "rgb_led_strip_bit_serializer_unit_macros.svh"
module rgb_led_strip_bit_serializer_unit import lsbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DAT_W-1:0]  s_tdata,  // red, green, blue, white, brightness,
	                                       // pixel_count, following, zero fill
	input  logic                 s_tuser,  // cmd
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_DAT_W-1:0] m_tdata,  // pin_level, busy_res, status, zero fill
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	lsbs_cfg_t               cfg_q;
	logic                    white_q;
	logic                    following_q;
	logic                    out_valid_q;
	logic [OUT_DAT_W-1:0]    out_data_q;

	lsbs_load_t              load;
	lsbs_buf_stat_t          buf_stat;
	lsbs_step_t              step;
	lsbs_ser_stat_t          ser_stat;
	logic [ADDR_W-1:0]       rd_addr;
	logic [7:0]              rd_data;

	logic                    accept;
	logic                    slot_free;
	logic                    is_load;
	logic                    refused;
	logic                    fin;
	logic                    emit;
	logic [OUT_DAT_W-1:0]    out_data_d;

	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = !buf_stat.busy && slot_free;
	assign accept    = s_tvalid && s_tready;
	assign is_load   = s_tuser;
	assign refused   = accept && is_load && !ser_stat.can_load;
	assign fin       = buf_stat.done && slot_free;

	always_comb begin
		load.red        = s_tdata[IN_RED +: 8];
		load.green      = s_tdata[IN_GREEN +: 8];
		load.blue       = s_tdata[IN_BLUE +: 8];
		load.white      = s_tdata[IN_WHITE +: 8];
		load.brightness = s_tdata[IN_BRIGHT +: 8];
		load.count      = s_tdata[IN_COUNT +: CNT_W];
		load.four       = white_q;
		load.start      = accept && is_load && ser_stat.can_load && (load.count != '0);
		step.any         = accept;
		step.tick        = accept && !is_load;
		step.start_frame = fin && !following_q;
		emit             = (accept && !load.start) || fin;
		out_data_d             = '0;
		out_data_d[OUT_PIN]    = ser_stat.pin;
		out_data_d[OUT_BUSY]   = ser_stat.busy_next;
		out_data_d[OUT_STATUS] = refused;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_high <= PER_W'(35);
			cfg_q.one_high  <= PER_W'(80);
			cfg_q.period    <= PER_W'(125);
			cfg_q.gap       <= TICK_W'(25000);
			white_q         <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ZERO_HIGH: cfg_q.zero_high <= cfg_data[PER_W-1:0];
				REG_ONE_HIGH:  cfg_q.one_high  <= cfg_data[PER_W-1:0];
				REG_PERIOD:    cfg_q.period    <= cfg_data[PER_W-1:0];
				REG_GAP:       cfg_q.gap       <= cfg_data[TICK_W-1:0];
				REG_WHITE:     white_q         <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load.start) begin
			following_q <= s_tdata[IN_FOLLOW];
		end
		if (emit) begin
			out_data_q <= out_data_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	lsbs_buffer u_buffer (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.clear_fill (ser_stat.clear_fill),
		.done_ack   (fin),
		.rd_addr    (rd_addr),
		.stat       (buf_stat),
		.rd_data    (rd_data)
	);

	lsbs_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.cfg        (cfg_q),
		.fill       (buf_stat.fill),
		.first_byte (buf_stat.first_byte),
		.rd_data    (rd_data),
		.stat       (ser_stat),
		.rd_addr    (rd_addr)
	);

	`LSBS_ASSERT_NXT(a_refused_status, clk, arst_n, refused, m_tvalid && m_tdata[OUT_STATUS], "refused load not flagged")
	`LSBS_ASSERT_IMP(a_fill_idle, clk, arst_n, buf_stat.busy, ser_stat.idle, "pixel memory written while a frame runs")
	`LSBS_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, buf_stat.fill <= FILL_W'(BUF_BYTES), "fill count beyond capacity")
	`LSBS_ASSERT_NXT(a_fill_stalls, clk, arst_n, load.start, !s_tready, "transaction taken while filling")

endmodule

// ----- rtl/core/lsbs_buffer.sv -----
module lsbs_buffer import lsbs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lsbs_load_t            load,
	input  logic                  clear_fill,
	input  logic                  done_ack,
	input  logic [ADDR_W-1:0]     rd_addr,
	output lsbs_buf_stat_t        stat,
	output logic [7:0]            rd_data
);

	localparam logic [1:0] BS_IDLE = 2'd0;
	localparam logic [1:0] BS_FILL = 2'd1;
	localparam logic [1:0] BS_DONE = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [1:0]        sub_q;
	logic              four_q;
	logic [FILL_W-1:0] fill_q;
	logic [3:0][7:0]   lvl_q;
	logic [7:0]        first_q;
	logic [7:0]        pixel_mem_q [BUF_BYTES];
	logic [7:0]        rd_data_q;

	logic [1:0]        last_sub;
	logic [FILL_W:0]   fill_after;
	logic              room;
	logic              pix_end;
	logic              wr_en;
	logic [7:0]        wr_byte;

	always_comb begin
		last_sub   = four_q ? 2'd3 : 2'd2;
		fill_after = {1'b0, fill_q} + (four_q ? (FILL_W+1)'(4) : (FILL_W+1)'(3));
		room       = fill_after <= (FILL_W+1)'(BUF_BYTES);
		pix_end    = (sub_q == 2'd0) && ((cnt_q == '0) || !room);
		wr_en      = (state_q == BS_FILL) && !pix_end;
		wr_byte    = lvl_q[sub_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			cnt_q   <= '0;
			sub_q   <= 2'd0;
			four_q  <= 1'b0;
		end else begin
			unique case (state_q)
				BS_IDLE: begin
					if (load.start) begin
						state_q <= BS_FILL;
						cnt_q   <= load.count;
						sub_q   <= 2'd0;
						four_q  <= load.four;
					end
				end
				BS_FILL: begin
					if (pix_end) begin
						state_q <= BS_DONE;
					end else if (sub_q == last_sub) begin
						sub_q <= 2'd0;
						cnt_q <= cnt_q - 1'b1;
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end
				BS_DONE: begin
					if (done_ack) begin
						state_q <= BS_IDLE;
					end
				end
				default: begin
					state_q <= BS_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (clear_fill) begin
			fill_q <= '0;
		end else if (wr_en) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load.start) begin
			lvl_q[0] <= scale_level(load.green, load.brightness);
			lvl_q[1] <= scale_level(load.red, load.brightness);
			lvl_q[2] <= scale_level(load.blue, load.brightness);
			lvl_q[3] <= scale_level(load.white, load.brightness);
		end
		if (wr_en && (fill_q == '0)) begin
			first_q <= wr_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pixel_mem_q[fill_q[ADDR_W-1:0]] <= wr_byte;
		end
		rd_data_q <= pixel_mem_q[rd_addr];
	end

	assign rd_data         = rd_data_q;
	assign stat.busy       = state_q != BS_IDLE;
	assign stat.done       = state_q == BS_DONE;
	assign stat.fill       = fill_q;
	assign stat.first_byte = first_q;

endmodule

// ----- rtl/core/lsbs_serializer.sv -----
module lsbs_serializer import lsbs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  lsbs_step_t        step,
	input  lsbs_cfg_t         cfg,
	input  logic [FILL_W-1:0] fill,
	input  logic [7:0]        first_byte,
	input  logic [7:0]        rd_data,
	output lsbs_ser_stat_t    stat,
	output logic [ADDR_W-1:0] rd_addr
);

	logic [1:0]        phase_q;
	logic [TICK_W-1:0] tick_q;
	logic [FILL_W-1:0] byte_q;
	logic [2:0]        bit_q;
	logic [7:0]        shift_q;

	logic [1:0]        ph_d;
	logic [TICK_W-1:0] tk_d;
	logic [FILL_W-1:0] byte_d;
	logic [2:0]        bit_d;
	logic [7:0]        sh_d;
	logic              pin;
	logic              clr;
	logic              gap_over;
	logic [PER_W-1:0]  period;
	logic [PER_W-1:0]  high;
	logic [TICK_W-1:0] tk_inc;
	logic [FILL_W-1:0] byte_inc;
	logic [1:0]        gap_phase;

	always_comb begin
		ph_d      = phase_q;
		tk_d      = tick_q;
		byte_d    = byte_q;
		bit_d     = bit_q;
		sh_d      = shift_q;
		pin       = 1'b0;
		clr       = 1'b0;
		gap_over  = (phase_q == PH_GAP) && (tick_q >= cfg.gap);
		period    = (cfg.period == '0) ? PER_W'(1) : cfg.period;
		high      = shift_q[7] ? cfg.one_high : cfg.zero_high;
		tk_inc    = tick_q + 1'b1;
		byte_inc  = byte_q + 1'b1;
		gap_phase = (cfg.gap == '0) ? PH_IDLE : PH_GAP;

		if (step.any && gap_over) begin
			ph_d = PH_IDLE;
			tk_d = '0;
		end

		if (step.tick && (ph_d == PH_SEND)) begin
			pin = tick_q < TICK_W'(high);
			if (tk_inc >= TICK_W'(period)) begin
				tk_d  = '0;
				sh_d  = {shift_q[6:0], 1'b0};
				bit_d = bit_q + 1'b1;
				if (bit_q == 3'd7) begin
					if ((byte_inc >= fill) || (byte_inc >= FILL_W'(BUF_BYTES))) begin
						byte_d = '0;
						clr    = 1'b1;
						ph_d   = gap_phase;
					end else begin
						byte_d = byte_inc;
						sh_d   = rd_data;
					end
				end
			end else begin
				tk_d = tk_inc;
			end
		end else if (step.tick && (ph_d == PH_GAP)) begin
			tk_d = tk_inc;
			if (tk_inc >= cfg.gap) begin
				ph_d = PH_IDLE;
				tk_d = '0;
			end
		end

		if (step.start_frame) begin
			tk_d = '0;
			if (fill == '0) begin
				clr  = 1'b1;
				ph_d = gap_phase;
			end else begin
				ph_d   = PH_SEND;
				byte_d = '0;
				bit_d  = 3'd0;
				sh_d   = first_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_GAP;
			tick_q  <= '0;
			byte_q  <= '0;
			bit_q   <= 3'd0;
			shift_q <= 8'd0;
		end else begin
			phase_q <= ph_d;
			tick_q  <= tk_d;
			byte_q  <= byte_d;
			bit_q   <= bit_d;
			shift_q <= sh_d;
		end
	end

	assign rd_addr         = byte_inc[ADDR_W-1:0];
	assign stat.pin        = pin;
	assign stat.busy_next  = ph_d != PH_IDLE;
	assign stat.can_load   = (phase_q == PH_IDLE) || gap_over;
	assign stat.idle       = phase_q == PH_IDLE;
	assign stat.clear_fill = clr;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import lsbs_pkg::*;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	typedef struct packed {
		logic             cmd;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [7:0]       white;
		logic [7:0]       bright;
		logic [CNT_W-1:0] count;
		logic             follow;
	} strip_item_t;

	typedef struct packed {
		logic pin;
		logic busy;
		logic status;
	} line_state_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_DAT_W-1:0]  s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_DAT_W-1:0] m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	strip_item_t pending_items[$];
	line_state_t expected_line[$];
	strip_item_t cur_item;
	line_state_t got_line;
	line_state_t want_line;
	logic        s_fired = 1'b0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	logic        rx_hold = 1'b0;
	int          n_accepted = 0;
	int          items_queued = 0;
	int          fail_count = 0;

	// line model state and register copies
	logic [7:0]  pix_mem [BUF_BYTES];
	int unsigned ln_fill;
	logic [1:0]  ln_phase;
	int unsigned ln_byte;
	logic [2:0]  ln_bit;
	logic [7:0]  ln_shift;
	int unsigned ln_ticks;
	int unsigned zero_len;
	int unsigned one_len;
	int unsigned period_len;
	int unsigned gap_len;
	logic        white_on;

	rgb_led_strip_bit_serializer_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [7:0] dim_level(input logic [7:0] c, input logic [7:0] b);
		int unsigned prod;
		prod = int'(c) * int'(b) + 255;
		return 8'(prod >> 8);
	endfunction

	function automatic void open_gap();
		ln_fill = 0;
		ln_ticks = 0;
		ln_phase = (gap_len == 0) ? PH_IDLE : PH_GAP;
	endfunction

	function automatic line_state_t led_predict_step(input strip_item_t it);
		line_state_t r;
		int unsigned bpp;
		int unsigned left;
		int unsigned per;
		int unsigned hi;
		logic [7:0]  lv_r;
		logic [7:0]  lv_g;
		logic [7:0]  lv_b;
		logic [7:0]  lv_w;
		r = '0;
		if (ln_phase == PH_GAP && ln_ticks >= gap_len) begin
			ln_phase = PH_IDLE;
			ln_ticks = 0;
		end
		if (it.cmd == CMD_LOAD) begin
			if (ln_phase != PH_IDLE) begin
				r.status = 1'b1;
			end else if (it.count != 0) begin
				bpp = white_on ? 4 : 3;
				lv_r = dim_level(it.red, it.bright);
				lv_g = dim_level(it.green, it.bright);
				lv_b = dim_level(it.blue, it.bright);
				lv_w = dim_level(it.white, it.bright);
				left = it.count;
				while (left != 0 && ln_fill + bpp <= BUF_BYTES) begin
					pix_mem[ln_fill] = lv_g;
					pix_mem[ln_fill + 1] = lv_r;
					pix_mem[ln_fill + 2] = lv_b;
					if (white_on)
						pix_mem[ln_fill + 3] = lv_w;
					ln_fill += bpp;
					left--;
				end
				if (!it.follow) begin
					if (ln_fill == 0) begin
						open_gap();
					end else begin
						ln_phase = PH_SEND;
						ln_byte = 0;
						ln_bit = 3'd0;
						ln_ticks = 0;
						ln_shift = pix_mem[0];
					end
				end
			end
		end else if (ln_phase == PH_SEND) begin
			per = (period_len == 0) ? 1 : period_len;
			hi = ln_shift[7] ? one_len : zero_len;
			r.pin = (ln_ticks < hi);
			ln_ticks++;
			if (ln_ticks >= per) begin
				ln_ticks = 0;
				ln_shift = ln_shift << 1;
				ln_bit = ln_bit + 3'd1;
				if (ln_bit == 3'd0) begin
					ln_byte++;
					if (ln_byte >= ln_fill || ln_byte >= BUF_BYTES) begin
						ln_byte = 0;
						open_gap();
					end else begin
						ln_shift = pix_mem[ln_byte];
					end
				end
			end
		end else if (ln_phase == PH_GAP) begin
			ln_ticks = (ln_ticks + 1) & 32'hFFFF;
			if (ln_ticks >= gap_len) begin
				ln_phase = PH_IDLE;
				ln_ticks = 0;
			end
		end
		r.busy = (ln_phase != PH_IDLE);
		return r;
	endfunction

	function automatic logic [IN_DAT_W-1:0] pack_item(input strip_item_t it);
		logic [IN_DAT_W-1:0] d;
		d = '0;
		d[IN_RED +: 8] = it.red;
		d[IN_GREEN +: 8] = it.green;
		d[IN_BLUE +: 8] = it.blue;
		d[IN_WHITE +: 8] = it.white;
		d[IN_BRIGHT +: 8] = it.bright;
		d[IN_COUNT +: CNT_W] = it.count;
		d[IN_FOLLOW] = it.follow;
		return d;
	endfunction

	function automatic strip_item_t make_load();
		strip_item_t it;
		it.cmd = CMD_LOAD;
		it.red = 8'($urandom_range(0, 255));
		it.green = 8'($urandom_range(0, 255));
		it.blue = 8'($urandom_range(0, 255));
		it.white = 8'($urandom_range(0, 255));
		it.bright = 8'($urandom_range(0, 255));
		it.count = CNT_W'($urandom_range(0, 7));
		it.follow = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic void log_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endfunction

	task automatic queue_item(input strip_item_t it);
		pending_items.push_back(it);
		items_queued++;
	endtask

	// push ticks; refused loads are mixed in while the line is expected to be busy
	task automatic queue_ticks(input int unsigned n, input int unsigned busy_n);
		strip_item_t it;
		for (int unsigned t = 0; t < n; t++) begin
			it = make_load();
			if (t >= busy_n || $urandom_range(0, 24) != 0)
				it.cmd = CMD_TICK;
			queue_item(it);
		end
	endtask

	task automatic queue_sequence(input bit big_ok, input bit force_big);
		strip_item_t it;
		int unsigned nloads;
		int unsigned est;
		int unsigned bpp;
		int unsigned fits;
		int unsigned pick;
		int unsigned per;
		int unsigned busy_n;
		int unsigned n;
		nloads = $urandom_range(0, 1);
		bpp = white_on ? 4 : 3;
		est = 0;
		for (int unsigned i = 0; i <= nloads; i++) begin
			it = make_load();
			it.follow = (i != nloads);
			pick = $urandom_range(0, 19);
			if (force_big && i == nloads)
				it.count = CNT_W'(1023);
			else if (pick == 0)
				it.count = '0;
			else if (big_ok && pick == 1)
				it.count = CNT_W'($urandom_range(64, 1023));
			else
				it.count = CNT_W'($urandom_range(1, 2));
			fits = (BUF_BYTES - est) / bpp;
			est += ((it.count < fits) ? it.count : fits) * bpp;
			queue_item(it);
		end
		per = (period_len == 0) ? 1 : period_len;
		busy_n = est * 8 * per + gap_len;
		n = busy_n + $urandom_range(0, 3);
		if ($urandom_range(0, 9) == 0)
			n = $urandom_range(0, n);
		queue_ticks(n, busy_n);
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || expected_line.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val[CFG_DAT_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ZERO_HIGH: zero_len = val & 32'h3FF;
			REG_ONE_HIGH:  one_len = val & 32'h3FF;
			REG_PERIOD:    period_len = val & 32'h3FF;
			REG_GAP:       gap_len = val & 32'hFFFF;
			REG_WHITE:     white_on = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_timing(input int unsigned z, input int unsigned o, input int unsigned p,
		input int unsigned g, input int unsigned w);
		write_reg(REG_ZERO_HIGH, z);
		write_reg(REG_ONE_HIGH, o);
		write_reg(REG_PERIOD, p);
		write_reg(REG_GAP, g);
		write_reg(REG_WHITE, w);
	endtask

	task automatic run_phase(input int unsigned n, input bit big_ok, input bit pause_mid);
		int unsigned start;
		bit paused;
		start = items_queued;
		paused = 1'b0;
		queue_sequence(big_ok, big_ok);
		while (items_queued - start < n) begin
			if (pause_mid && !paused && items_queued - start >= n / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			queue_sequence(big_ok, 1'b0);
		end
	endtask

	always @(negedge clk) begin
		if (!s_tvalid || s_fired) begin
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tuser <= pending_items[0].cmd;
				s_tdata <= pack_item(pending_items[0]);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		s_fired = arst_n && s_tvalid && s_tready;
		if (s_fired) begin
			cur_item = pending_items.pop_front();
			expected_line.push_back(led_predict_step(cur_item));
			n_accepted++;
		end
	end

	always @(negedge clk) begin
		m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_line.pin = m_tdata[OUT_PIN];
			got_line.busy = m_tdata[OUT_BUSY];
			got_line.status = m_tdata[OUT_STATUS];
			if (expected_line.size() == 0) begin
				log_failure($sformatf("%0t: transaction with nothing expected, data %b",
					$time, m_tdata));
			end else begin
				want_line = expected_line.pop_front();
				if (got_line.pin !== want_line.pin || got_line.busy !== want_line.busy ||
					got_line.status !== want_line.status)
					log_failure($sformatf(
						"%0t: pin exp %b got %b, busy exp %b got %b, status exp %b got %b",
						$time, want_line.pin, got_line.pin, want_line.busy, got_line.busy,
						want_line.status, got_line.status));
			end
		end
	end

	// long receiver stall while items keep coming
	initial begin
		wait (n_accepted >= 250);
		rx_hold = 1'b1;
		repeat (400) @(posedge clk);
		rx_hold = 1'b0;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		strip_item_t it;
		ln_fill = 0;
		ln_phase = PH_GAP;
		ln_byte = 0;
		ln_bit = 3'd0;
		ln_shift = 8'd0;
		ln_ticks = 0;
		zero_len = 35;
		one_len = 80;
		period_len = 125;
		gap_len = 25000;
		white_on = 1'b0;
		tx_idle_pct = 35;
		rx_idle_pct = 62;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// gap after reset still running: load refused
		it = make_load();
		it.cmd = CMD_TICK;
		queue_item(it);
		it = make_load();
		it.count = CNT_W'(1);
		it.follow = 1'b0;
		queue_item(it);
		it.cmd = CMD_TICK;
		queue_item(it);
		wait_drained();
		set_timing(1, 2, 3, 4, 0);
		queue_ticks(3, 0);
		it = make_load();
		it.count = '0;
		it.follow = 1'b0;
		queue_item(it);
		it = make_load();
		it.red = 8'd255;
		it.green = 8'd0;
		it.blue = 8'd170;
		it.white = 8'd85;
		it.bright = 8'd255;
		it.count = CNT_W'(1);
		it.follow = 1'b1;
		queue_item(it);
		it.red = 8'd0;
		it.green = 8'd255;
		it.blue = 8'd85;
		it.white = 8'd170;
		it.bright = 8'd0;
		queue_item(it);
		it.red = 8'd128;
		it.green = 8'd1;
		it.blue = 8'd254;
		it.bright = 8'd128;
		it.follow = 1'b0;
		queue_item(it);
		queue_ticks(9 * 8 * 3 + 4 + 2, 9 * 8 * 3);

		wait_drained();
		set_timing(1, 2, 3, 5, 0);
		run_phase(40, 1'b0, 1'b0);
		wait_drained();
		set_timing(2, 1, 4, 0, 1);
		run_phase(40, 1'b0, 1'b0);

		wait_drained();
		tx_idle_pct = 62;
		rx_idle_pct = 35;
		set_timing(0, 1023, 2, 3, 0);
		run_phase(80, 1'b0, 1'b1);
		wait_drained();
		set_timing(3, 5, 0, 1, 1);
		run_phase(40, 1'b0, 1'b0);

		wait_drained();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_timing(1023, 1023, 1023, 65535, 1);
		write_reg(REG_UNMAPPED, 16'hFFFF);
		it = make_load();
		it.count = CNT_W'(1);
		it.follow = 1'b1;
		queue_item(it);
		wait_drained();
		write_reg(REG_WHITE, 0);
		it = make_load();
		it.count = CNT_W'(1);
		it.follow = 1'b0;
		queue_item(it);
		queue_ticks(24, 0);
		wait_drained();
		// retime a frame in flight, then sit in a long gap
		write_reg(REG_ZERO_HIGH, 1);
		write_reg(REG_ONE_HIGH, 1);
		write_reg(REG_PERIOD, 2);
		queue_ticks(7 * 8 * 2 + 20, 7 * 8 * 2 + 20);
		wait_drained();
		write_reg(REG_GAP, 0);
		it = make_load();
		it.count = CNT_W'(2);
		it.follow = 1'b0;
		queue_item(it);
		queue_ticks(6 * 8 * 2 + 4, 6 * 8 * 2);

		wait_drained();
		set_timing(1, 3, 5, 2, 0);
		run_phase(60, 1'b0, 1'b0);

		// drain any frame left running, then overfill the buffer and start a long frame
		wait_drained();
		set_timing(1, 1, 1, 0, 0);
		queue_ticks(100, 0);
		it = make_load();
		it.count = CNT_W'(1023);
		it.follow = 1'b1;
		queue_item(it);
		it = make_load();
		it.count = CNT_W'(1);
		it.follow = 1'b0;
		queue_item(it);
		queue_ticks(40, 40);

		wait_drained();
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- rgb_led_strip_bit_serializer_unit.f -----
+incdir+rtl/core
rtl/core/lsbs_pkg.sv
rtl/core/lsbs_buffer.sv
rtl/core/lsbs_serializer.sv
rtl/core/rgb_led_strip_bit_serializer_unit.sv
dv/testbench.sv
